/* sv/ttcs_pkg.sv */
// -----------------------------------------------------------------------------
// ttcs_pkg
// Shared types and constants of the text terminal engine: command and
// character codes, register indexes, request/response words, queue entry.
// -----------------------------------------------------------------------------
package ttcs_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;
   localparam logic [7:0] CH_SPACE     = 8'd32;

   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTRIBUTE = 2'd2;

   localparam logic [6:0] RESET_COLUMNS   = 7'd80;
   localparam logic [4:0] RESET_ROWS      = 5'd25;
   localparam logic [7:0] RESET_ATTRIBUTE = 8'd7;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  char_byte;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [10:0] cursor_position;
      logic [15:0] cell_value;
      logic        did_scroll;
   } rsp_type;

   typedef struct packed {
      logic [6:0] columns_in_use;
      logic [4:0] rows_in_use;
      logic [7:0] text_attribute;
   } cfg_type;

   typedef enum logic [2:0] {
      K_PRINT,
      K_NEWLINE,
      K_RETURN,
      K_BACKSPACE,
      K_CLEAR,
      K_READ,
      K_NOP
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  char_byte;
      logic [10:0] cell_index;
   } desc_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_COPY,
      S_FILL
   } state_type;

endpackage

/* sv/ttcs_front.sv */
// -----------------------------------------------------------------------------
// ttcs_front
// Command front end: accepts a request word and decodes it into a queue entry.
// -----------------------------------------------------------------------------
module ttcs_front (
   input  ttcs_pkg::req_type  req_data,
   input  logic               start,
   input  logic               queue_full,
   input  logic               sweeping,
   output logic               busy,
   output logic               push,
   output ttcs_pkg::desc_type desc
);
   import ttcs_pkg::*;

   assign busy = queue_full | sweeping;
   assign push = start & ~busy;

   always_comb begin
      desc.char_byte  = req_data.char_byte;
      desc.cell_index = req_data.cell_index;
      unique case (req_data.cmd)
         CMD_PUT: begin
            unique case (req_data.char_byte)
               CH_NEWLINE:   desc.kind = K_NEWLINE;
               CH_RETURN:    desc.kind = K_RETURN;
               CH_BACKSPACE: desc.kind = K_BACKSPACE;
               default:      desc.kind = K_PRINT;
            endcase
         end
         CMD_CLEAR: desc.kind = K_CLEAR;
         CMD_READ:  desc.kind = K_READ;
         default:   desc.kind = K_NOP;
      endcase
   end

endmodule

/* sv/ttcs_queue.sv */
// -----------------------------------------------------------------------------
// ttcs_queue
// Short command queue between the front end and the execution engine.
// -----------------------------------------------------------------------------
module ttcs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ttcs_pkg::desc_type push_data,
   input  logic               pop,
   output ttcs_pkg::desc_type head,
   output logic               not_empty,
   output logic               full
);
   import ttcs_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   desc_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CNT_W'(QUEUE_DEPTH) || pop))
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue underflow");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count lost a word");

endmodule

/* sv/ttcs_back.sv */
// -----------------------------------------------------------------------------
// ttcs_back
// Execution engine: cursor update, screen store, scroll copy and fill sweeps.
// -----------------------------------------------------------------------------
module ttcs_back #(
   parameter int MAX_COLUMNS = 80,
   parameter int MAX_ROWS    = 25
) (
   input  logic               clock,
   input  logic               reset,
   input  ttcs_pkg::cfg_type  cfg,
   input  ttcs_pkg::desc_type desc,
   input  logic               desc_valid,
   output logic               desc_pop,
   output logic               sweeping,
   output logic               rsp_valid,
   output ttcs_pkg::rsp_type  rsp_data
);
   import ttcs_pkg::*;

   localparam int STORE_CELLS = MAX_COLUMNS * MAX_ROWS;
   localparam int AW  = (STORE_CELLS > 1) ? $clog2(STORE_CELLS) : 1;
   localparam int CNW = $clog2(MAX_COLUMNS + 1);
   localparam int RNW = $clog2(MAX_ROWS + 1);
   localparam int PW  = CNW + RNW;
   localparam logic [15:0] RESET_BLANK = {RESET_ATTRIBUTE, CH_SPACE};

   logic [15:0]    mem [STORE_CELLS];

   state_type      state_ff, state_in;
   logic [RNW-1:0] row_ff, row_in;
   logic [CNW-1:0] col_ff, col_in;
   logic [PW-1:0]  cp_ff, cp_in;
   logic           pend_ff, pend_in;
   logic [AW-1:0]  pend_addr_ff, pend_addr_in;
   logic [PW-1:0]  fill_ptr_ff, fill_ptr_in;
   logic [PW-1:0]  fill_end_ff, fill_end_in;
   logic [15:0]    fill_val_ff, fill_val_in;
   logic           fill_emit_ff, fill_emit_in;
   logic           scrolled_ff, scrolled_in;
   logic [PW-1:0]  pos_ff, pos_in;
   logic           rd_ok_ff, rd_ok_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;
   logic [15:0]    rd_data_ff;

   logic [CNW-1:0] cols;
   logic [RNW-1:0] rows;
   logic [CNW-1:0] c0, c1, wa_col;
   logic [RNW-1:0] r0, r1, wa_row;
   logic           put_we, scroll, fill_last;
   logic [15:0]    put_data, blank;
   logic [PW-1:0]  put_addr, pos_step, moved, copy_src, fill_next;
   logic           mem_we;
   logic [AW-1:0]  mem_waddr, mem_raddr;
   logic [15:0]    mem_wdata;

   always_comb begin
      if (cfg.columns_in_use == '0) begin
         cols = CNW'(1);
      end else if (int'(cfg.columns_in_use) > MAX_COLUMNS) begin
         cols = CNW'(MAX_COLUMNS);
      end else begin
         cols = CNW'(cfg.columns_in_use);
      end
      if (cfg.rows_in_use == '0) begin
         rows = RNW'(1);
      end else if (int'(cfg.rows_in_use) > MAX_ROWS) begin
         rows = RNW'(MAX_ROWS);
      end else begin
         rows = RNW'(cfg.rows_in_use);
      end
   end

   assign blank     = {cfg.text_attribute, CH_SPACE};
   assign moved     = PW'(rows - RNW'(1)) * PW'(cols);
   assign copy_src  = cp_ff + PW'(cols);
   assign fill_next = fill_ptr_ff + PW'(1);
   assign fill_last = (fill_next == fill_end_ff);
   assign sweeping  = (state_ff == S_FILL) && !fill_emit_ff;

   // cursor step for the entry at the queue head
   always_comb begin
      c0       = (col_ff >= cols) ? cols - CNW'(1) : col_ff;
      r0       = (row_ff >= rows) ? rows - RNW'(1) : row_ff;
      c1       = c0;
      r1       = r0;
      put_we   = 1'b0;
      put_data = {cfg.text_attribute, desc.char_byte};
      unique case (desc.kind)
         K_PRINT: begin
            put_we = 1'b1;
            if (c0 + CNW'(1) >= cols) begin
               c1 = '0;
               r1 = r0 + RNW'(1);
            end else begin
               c1 = c0 + CNW'(1);
            end
         end
         K_NEWLINE: begin
            c1 = '0;
            r1 = r0 + RNW'(1);
         end
         K_RETURN: c1 = '0;
         K_BACKSPACE: begin
            put_data = blank;
            if (c0 != '0) begin
               c1     = c0 - CNW'(1);
               put_we = 1'b1;
            end else if (r0 != '0) begin
               r1     = r0 - RNW'(1);
               c1     = cols - CNW'(1);
               put_we = 1'b1;
            end
         end
         default: ;
      endcase
      if (desc.kind == K_BACKSPACE) begin
         wa_row = r1;
         wa_col = c1;
      end else begin
         wa_row = r0;
         wa_col = c0;
      end
      scroll   = (r1 >= rows);
      put_addr = PW'(wa_row) * PW'(cols) + PW'(wa_col);
      pos_step = PW'(r1) * PW'(cols) + PW'(c1);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (desc_valid) begin
               if (desc.kind == K_READ) begin
                  state_in = S_READ;
               end else if (desc.kind == K_CLEAR) begin
                  state_in = S_FILL;
               end else if (scroll) begin
                  state_in = S_COPY;
               end
            end
         end
         S_READ: state_in = S_IDLE;
         S_COPY: begin
            if (cp_ff == moved) begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            if (fill_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      desc_pop     = 1'b0;
      row_in       = row_ff;
      col_in       = col_ff;
      cp_in        = cp_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      fill_ptr_in  = fill_ptr_ff;
      fill_end_in  = fill_end_ff;
      fill_val_in  = fill_val_ff;
      fill_emit_in = fill_emit_ff;
      scrolled_in  = scrolled_ff;
      pos_in       = pos_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_raddr    = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (desc_valid) begin
               desc_pop  = 1'b1;
               row_in    = r1;
               col_in    = c1;
               pos_in    = pos_step;
               mem_raddr = AW'(desc.cell_index);
               rd_ok_in  = int'(desc.cell_index) < STORE_CELLS;
               if (put_we) begin
                  mem_we    = 1'b1;
                  mem_waddr = put_addr[AW-1:0];
                  mem_wdata = put_data;
               end
               unique case (desc.kind)
                  K_CLEAR: begin
                     row_in       = '0;
                     col_in       = '0;
                     pos_in       = '0;
                     fill_ptr_in  = '0;
                     fill_end_in  = PW'(STORE_CELLS);
                     fill_val_in  = blank;
                     fill_emit_in = 1'b1;
                     scrolled_in  = 1'b0;
                  end
                  K_READ: ;
                  default: begin
                     if (scroll) begin
                        row_in       = rows - RNW'(1);
                        col_in       = '0;
                        pos_in       = moved;
                        cp_in        = '0;
                        fill_ptr_in  = moved;
                        fill_end_in  = moved + PW'(cols);
                        fill_val_in  = blank;
                        fill_emit_in = 1'b1;
                        scrolled_in  = 1'b1;
                     end else begin
                        rsp_valid_in                = 1'b1;
                        rsp_data_in.cursor_position = 11'(pos_step);
                        rsp_data_in.cell_value      = '0;
                        rsp_data_in.did_scroll      = 1'b0;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in                = 1'b1;
            rsp_data_in.cursor_position = 11'(pos_ff);
            rsp_data_in.cell_value      = rd_ok_ff ? rd_data_ff : '0;
            rsp_data_in.did_scroll      = 1'b0;
         end
         S_COPY: begin
            if (cp_ff != moved) begin
               mem_raddr    = copy_src[AW-1:0];
               pend_in      = 1'b1;
               pend_addr_in = cp_ff[AW-1:0];
               cp_in        = cp_ff + PW'(1);
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pend_addr_ff;
               mem_wdata = rd_data_ff;
            end
         end
         S_FILL: begin
            mem_we      = 1'b1;
            mem_waddr   = fill_ptr_ff[AW-1:0];
            mem_wdata   = fill_val_ff;
            fill_ptr_in = fill_next;
            if (fill_last && fill_emit_ff) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.cursor_position = 11'(pos_ff);
               rsp_data_in.cell_value      = '0;
               rsp_data_in.did_scroll      = scrolled_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         row_ff       <= '0;
         col_ff       <= '0;
         pend_ff      <= 1'b0;
         fill_ptr_ff  <= '0;
         fill_end_ff  <= PW'(STORE_CELLS);
         fill_val_ff  <= RESET_BLANK;
         fill_emit_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         pend_ff      <= pend_in;
         fill_ptr_ff  <= fill_ptr_in;
         fill_end_ff  <= fill_end_in;
         fill_val_ff  <= fill_val_in;
         fill_emit_ff <= fill_emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_ff        <= cp_in;
      pend_addr_ff <= pend_addr_in;
      scrolled_ff  <= scrolled_in;
      pos_ff       <= pos_in;
      rd_ok_ff     <= rd_ok_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_fill_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FILL |-> fill_ptr_ff < fill_end_ff)
      else $error("fill pointer past end of range");

   a_pend_from_copy: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(state_ff) == S_COPY)
      else $error("copy write outside scroll");

   a_sweep_quiet: assert property (@(posedge clock) disable iff (reset)
      sweeping |-> !rsp_valid_ff && !desc_pop)
      else $error("activity during reset sweep");

endmodule

/* sv/text_terminal_cursor_scroll.sv */
// -----------------------------------------------------------------------------
// text_terminal_cursor_scroll
// Text-mode terminal engine with cursor, wrap, backspace, scroll and clear.
//
// Commands enter on req_data and are taken on a clock edge with start high
// and busy low; a two-word queue sits between the decoder and the engine.
// Every command yields one response word: rsp_valid is high for exactly one
// cycle with rsp_data, and the receiver cannot hold it off.
// Put, newline, return, backspace and the unused code run one word per cycle
// back to back when they do not scroll; a read holds the engine in S_READ
// before the next word is taken.
// Clear walks the whole store, MAX_COLUMNS*MAX_ROWS cells, one cell a cycle.
// A scroll copies (rows-1)*columns cells through the store, reading one and
// writing one a cycle, then blanks the bottom row.
// Reset sets the registers to their defaults and starts a sweep over all
// MAX_COLUMNS*MAX_ROWS cells that fills the store with blanks; busy stays
// high until it ends. Register writes on csr_wr_en are registered into cfg
// and take effect without handshake.
// -----------------------------------------------------------------------------
module text_terminal_cursor_scroll #(
   parameter int MAX_COLUMNS = 80,
   parameter int MAX_ROWS    = 25
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  ttcs_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output ttcs_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [ttcs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ttcs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ttcs_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   desc_type front_desc, head;
   logic     push, pop, not_empty, full, sweeping;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COLUMNS:   cfg_in.columns_in_use = csr_wdata[6:0];
            CSR_ROWS:      cfg_in.rows_in_use    = csr_wdata[4:0];
            CSR_ATTRIBUTE: cfg_in.text_attribute = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.columns_in_use <= RESET_COLUMNS;
         cfg_ff.rows_in_use    <= RESET_ROWS;
         cfg_ff.text_attribute <= RESET_ATTRIBUTE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ttcs_front u_front (
      .req_data   (req_data),
      .start      (start),
      .queue_full (full),
      .sweeping   (sweeping),
      .busy       (busy),
      .push       (push),
      .desc       (front_desc)
   );

   ttcs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_desc),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .full      (full)
   );

   ttcs_back #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .desc       (head),
      .desc_valid (not_empty),
      .desc_pop   (pop),
      .sweeping   (sweeping),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

/* tb/tb_text_terminal_cursor_scroll.sv */
// -----------------------------------------------------------------------------
// tb_text_terminal_cursor_scroll
// Self-checking bench for the text terminal engine. A directed script walks
// the cursor and screen corner cases, then random command streams run under
// several screen geometries and sender idle rates. Every response word is
// checked against a script value or a cycle-free model of store and cursor.
// -----------------------------------------------------------------------------
module tb_text_terminal_cursor_scroll;
   timeunit 1ns;
   timeprecision 1ps;

   import ttcs_pkg::*;

   localparam int NUM_COLUMNS    = 80;
   localparam int NUM_ROWS       = 25;
   localparam int STORE_CELLS    = NUM_COLUMNS * NUM_ROWS;
   localparam int SETTLE_CYCLES  = 10;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASES         = 6;
   localparam int WORDS_PER_PHASE = 250;
   localparam int REQ_W          = $bits(req_type);
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic                   is_csr;
      logic [CSR_INDEX_W-1:0] csr_idx;
      logic [CSR_DATA_W-1:0]  csr_val;
      req_type                word;
      logic                   has_known;
      rsp_type                known;
   } row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   req_type                req_data = '0;
   logic                   rsp_valid;
   rsp_type                rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   logic [15:0] screen_model [STORE_CELLS];
   int          cur_row;
   int          cur_col;
   cfg_type     regs;
   rsp_type     reports_due [$];
   rsp_type     want;
   int          errors = 0;
   int          quiet_cycles = 0;

   text_terminal_cursor_scroll #(
      .MAX_COLUMNS(NUM_COLUMNS),
      .MAX_ROWS   (NUM_ROWS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int active_columns();
      if (regs.columns_in_use == 0) return 1;
      if (regs.columns_in_use > NUM_COLUMNS) return NUM_COLUMNS;
      return int'(regs.columns_in_use);
   endfunction

   function automatic int active_rows();
      if (regs.rows_in_use == 0) return 1;
      if (regs.rows_in_use > NUM_ROWS) return NUM_ROWS;
      return int'(regs.rows_in_use);
   endfunction

   function automatic rsp_type advance_terminal(req_type w);
      int      cols;
      int      rows;
      int      moved;
      rsp_type r;
      cols = active_columns();
      rows = active_rows();
      r = '0;
      if (cur_col >= cols) cur_col = cols - 1;
      if (cur_row >= rows) cur_row = rows - 1;
      case (w.cmd)
         CMD_PUT: begin
            case (w.char_byte)
               CH_NEWLINE: begin
                  cur_col = 0;
                  cur_row++;
               end
               CH_RETURN: cur_col = 0;
               CH_BACKSPACE: begin
                  if (cur_col > 0 || cur_row > 0) begin
                     if (cur_col > 0) begin
                        cur_col--;
                     end else begin
                        cur_row--;
                        cur_col = cols - 1;
                     end
                     screen_model[cur_row * cols + cur_col] = {regs.text_attribute, CH_SPACE};
                  end
               end
               default: begin
                  screen_model[cur_row * cols + cur_col] = {regs.text_attribute, w.char_byte};
                  cur_col++;
                  if (cur_col >= cols) begin
                     cur_col = 0;
                     cur_row++;
                  end
               end
            endcase
            if (cur_row >= rows) begin
               moved = (rows - 1) * cols;
               for (int i = 0; i < moved; i++) screen_model[i] = screen_model[i + cols];
               for (int i = 0; i < cols; i++)
                  screen_model[moved + i] = {regs.text_attribute, CH_SPACE};
               cur_row = rows - 1;
               cur_col = 0;
               r.did_scroll = 1'b1;
            end
         end
         CMD_CLEAR: begin
            for (int i = 0; i < STORE_CELLS; i++)
               screen_model[i] = {regs.text_attribute, CH_SPACE};
            cur_row = 0;
            cur_col = 0;
         end
         CMD_READ: begin
            if (w.cell_index < STORE_CELLS) r.cell_value = screen_model[w.cell_index];
         end
         default: ;
      endcase
      r.cursor_position = 11'(cur_row * cols + cur_col);
      return r;
   endfunction

   function automatic req_type random_word();
      req_type w;
      int      pick;
      w = REQ_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 1) begin
         w.cmd = CMD_CLEAR;
      end else if (pick < 56) begin
         w.cmd = CMD_PUT;
      end else if (pick < 64) begin
         w.cmd = CMD_PUT;
         w.char_byte = CH_NEWLINE;
      end else if (pick < 68) begin
         w.cmd = CMD_PUT;
         w.char_byte = CH_RETURN;
      end else if (pick < 77) begin
         w.cmd = CMD_PUT;
         w.char_byte = CH_BACKSPACE;
      end else if (pick < 96) begin
         w.cmd = CMD_READ;
         if ($urandom_range(0, 3) != 0)
            w.cell_index = 11'($urandom_range(0, active_columns() * active_rows() - 1));
      end else begin
         w.cmd = CMD_UNUSED;
      end
      return w;
   endfunction

   function automatic row_type word_row(logic [1:0] cmd, logic [7:0] ch, logic [10:0] idx);
      row_type r;
      r = '0;
      r.word = '{cmd: cmd, char_byte: ch, cell_index: idx};
      return r;
   endfunction

   function automatic row_type known_row(logic [1:0] cmd, logic [7:0] ch, logic [10:0] idx,
                                         logic [10:0] pos, logic [15:0] val, logic scr);
      row_type r;
      r = word_row(cmd, ch, idx);
      r.has_known = 1'b1;
      r.known = '{cursor_position: pos, cell_value: val, did_scroll: scr};
      return r;
   endfunction

   function automatic row_type csr_row(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      row_type r;
      r = '0;
      r.is_csr = 1'b1;
      r.csr_idx = idx;
      r.csr_val = val;
      return r;
   endfunction

   task automatic report_mismatch(string what);
      errors++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   task automatic issue(req_type w, logic typed, rsp_type typed_rsp);
      rsp_type predicted;
      start <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      predicted = advance_terminal(w);
      reports_due.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_COLUMNS:   regs.columns_in_use = val[6:0];
         CSR_ROWS:      regs.rows_in_use = val[4:0];
         CSR_ATTRIBUTE: regs.text_attribute = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (reports_due.size() == 0) begin
            report_mismatch("response word with nothing expected");
         end else begin
            want = reports_due.pop_front();
            if (rsp_data.cursor_position !== want.cursor_position)
               report_mismatch($sformatf("cursor_position got %0d want %0d",
                                         rsp_data.cursor_position, want.cursor_position));
            if (rsp_data.cell_value !== want.cell_value)
               report_mismatch($sformatf("cell_value got %h want %h",
                                         rsp_data.cell_value, want.cell_value));
            if (rsp_data.did_scroll !== want.did_scroll)
               report_mismatch($sformatf("did_scroll got %b want %b",
                                         rsp_data.did_scroll, want.did_scroll));
         end
      end
      if ((start && !busy) || rsp_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      row_type script [$];
      int      gap;
      int      phase_cols [PHASES];
      int      phase_rows [PHASES];
      int      phase_idle [PHASES];

      phase_cols = '{80, 8, 3, 127, 0, 0};
      phase_rows = '{25, 4, 2, 31, 0, 0};
      phase_idle = '{0, 85, 0, 18, 85, 0};

      regs = '{columns_in_use: RESET_COLUMNS, rows_in_use: RESET_ROWS,
               text_attribute: RESET_ATTRIBUTE};
      for (int i = 0; i < STORE_CELLS; i++) screen_model[i] = {RESET_ATTRIBUTE, CH_SPACE};
      cur_row = 0;
      cur_col = 0;

      script.push_back(known_row(CMD_READ, 8'h00, 11'd0, 11'd0, 16'h0720, 1'b0));
      script.push_back(known_row(CMD_READ, 8'h00, 11'd1999, 11'd0, 16'h0720, 1'b0));
      script.push_back(known_row(CMD_READ, 8'h00, 11'h7FF, 11'd0, 16'h0000, 1'b0));
      script.push_back(known_row(CMD_PUT, CH_BACKSPACE, 11'd0, 11'd0, 16'h0000, 1'b0));
      script.push_back(known_row(CMD_PUT, 8'h41, 11'd0, 11'd1, 16'h0000, 1'b0));
      script.push_back(known_row(CMD_PUT, 8'hFF, 11'd0, 11'd2, 16'h0000, 1'b0));
      script.push_back(known_row(CMD_READ, 8'h00, 11'd1, 11'd2, 16'h07FF, 1'b0));
      script.push_back(known_row(CMD_PUT, CH_BACKSPACE, 11'd0, 11'd1, 16'h0000, 1'b0));
      script.push_back(known_row(CMD_PUT, CH_NEWLINE, 11'd0, 11'd80, 16'h0000, 1'b0));
      script.push_back(known_row(CMD_PUT, 8'h00, 11'd0, 11'd81, 16'h0000, 1'b0));
      script.push_back(known_row(CMD_PUT, CH_RETURN, 11'd0, 11'd80, 16'h0000, 1'b0));
      script.push_back(known_row(CMD_PUT, CH_BACKSPACE, 11'd0, 11'd79, 16'h0000, 1'b0));
      script.push_back(known_row(CMD_UNUSED, 8'hFF, 11'h7FF, 11'd79, 16'h0000, 1'b0));
      script.push_back(known_row(CMD_CLEAR, 8'h00, 11'd0, 11'd0, 16'h0000, 1'b0));
      script.push_back(csr_row(CSR_ATTRIBUTE, 8'h00));
      script.push_back(csr_row(CSR_COLUMNS, 8'd2));
      script.push_back(csr_row(CSR_ROWS, 8'd1));
      script.push_back(word_row(CMD_PUT, 8'h78, 11'd0));
      script.push_back(known_row(CMD_PUT, 8'h79, 11'd0, 11'd0, 16'h0000, 1'b1));
      script.push_back(known_row(CMD_PUT, CH_NEWLINE, 11'd0, 11'd0, 16'h0000, 1'b1));
      script.push_back(word_row(CMD_READ, 8'h00, 11'd0));
      script.push_back(csr_row(CSR_COLUMNS, 8'd0));
      script.push_back(csr_row(CSR_ROWS, 8'd0));
      script.push_back(known_row(CMD_PUT, 8'h7A, 11'd0, 11'd0, 16'h0000, 1'b1));
      script.push_back(csr_row(CSR_COLUMNS, 8'd127));
      script.push_back(csr_row(CSR_ROWS, 8'd31));
      script.push_back(csr_row(CSR_ATTRIBUTE, 8'hFF));
      script.push_back(word_row(CMD_PUT, 8'h55, 11'd0));
      script.push_back(word_row(CMD_PUT, CH_NEWLINE, 11'd0));
      script.push_back(word_row(CMD_PUT, 8'h71, 11'd0));
      script.push_back(csr_row(CSR_COLUMNS, 8'd1));
      script.push_back(word_row(CMD_READ, 8'h00, 11'd0));
      script.push_back(csr_row(CSR_ROWS, 8'd1));
      script.push_back(word_row(CMD_READ, 8'h00, 11'd5));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_csr) begin
            settle();
            write_register(script[i].csr_idx, script[i].csr_val);
         end else begin
            issue(script[i].word, script[i].has_known, script[i].known);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         if (ph == 4) begin
            phase_cols[ph] = $urandom_range(1, 20);
            phase_rows[ph] = $urandom_range(1, 6);
         end
         write_register(CSR_COLUMNS, CSR_DATA_W'(phase_cols[ph]));
         write_register(CSR_ROWS, CSR_DATA_W'(phase_rows[ph]));
         write_register(CSR_ATTRIBUTE, CSR_DATA_W'($urandom_range(0, 255)));
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            issue(random_word(), 1'b0, '0);
            gap = 0;
            while ($urandom_range(0, 99) < phase_idle[ph]) gap++;
            if (gap > 0) begin
               start <= 1'b0;
               req_data <= REQ_W'($urandom);
               repeat (gap) @(posedge clock);
            end
         end
      end

      settle();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* text_terminal_cursor_scroll.f */
sv/ttcs_pkg.sv
sv/ttcs_front.sv
sv/ttcs_queue.sv
sv/ttcs_back.sv
sv/text_terminal_cursor_scroll.sv
tb/tb_text_terminal_cursor_scroll.sv
